@@ hw/rtl/state_space_derivative_defines.svh @@
// ----------------------------------------------------------------------------
// State-space derivative: assertion macros
// Shared property forms for the checker of the derivative block.
// ----------------------------------------------------------------------------
`ifndef STATE_SPACE_DERIVATIVE_DEFINES_SVH
`define STATE_SPACE_DERIVATIVE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after reset is seen low.
`define SSD_ASSERT_RESET(label, cons, msg) \
    label: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ssd_pkg.sv @@
// ----------------------------------------------------------------------------
// State-space derivative package
// Sizes, codes and beat types shared by the derivative block and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssd_pkg;

    localparam int MAX_STATES = 8;
    localparam int MAX_INPUTS = 4;
    localparam int ROW_CAP    = (MAX_STATES < 8) ? MAX_STATES : 8;
    localparam int MAX_DIM    = (MAX_STATES > MAX_INPUTS) ? MAX_STATES : MAX_INPUTS;

    localparam int MODE_W     = 2;
    localparam int ROW_W      = 3;
    localparam int COL_W      = 3;
    localparam int VALUE_W    = 32;
    localparam int SD_W       = 4;
    localparam int ID_W       = 3;
    localparam int CFG_DATA_W = 4;
    localparam int CFG_IDX_W  = 1;

    localparam int CNT_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    localparam int A_DEPTH    = MAX_STATES * MAX_STATES;
    localparam int B_DEPTH    = MAX_STATES * MAX_INPUTS;
    localparam int MAT_DEPTH  = A_DEPTH + B_DEPTH;
    localparam int MAT_AW     = $clog2(MAT_DEPTH);
    localparam int B_BASE     = A_DEPTH;
    localparam int VEC_DEPTH  = MAX_STATES + MAX_INPUTS;
    localparam int VEC_AW     = $clog2(VEC_DEPTH);
    localparam int U_BASE     = MAX_STATES;

    localparam int PROD_W     = 2 * VALUE_W;
    localparam int ACC_W      = PROD_W + $clog2(MAX_STATES + MAX_INPUTS);
    localparam int FRAC_W     = 16;
    localparam int RND_W      = ACC_W - FRAC_W;
    localparam int ROUND_HALF = 1 << (FRAC_W - 1);

    localparam logic signed [VALUE_W-1:0] SAT_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] SAT_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD_A = 2'd0,
        MODE_LOAD_B = 2'd1,
        MODE_SET_U  = 2'd2,
        MODE_STATE  = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STATE_DIM = 1'd0,
        CFG_INPUT_DIM = 1'd1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_RUN,
        SEQ_DRAIN
    } t_seq_state;

    typedef struct packed {
        t_mode                      mode;
        logic [ROW_W-1:0]           row;
        logic [COL_W-1:0]           col;
        logic signed [VALUE_W-1:0]  value;
        logic                       last;
    } t_item;

    typedef struct packed {
        logic [ROW_W-1:0]           index;
        logic signed [VALUE_W-1:0]  derivative;
        logic                       saturated;
        logic                       final_res;
    } t_result;

    // Tag that travels with each product through the multiply-accumulate pipe.
    typedef struct packed {
        logic             first_term;
        logic             last_term;
        logic [ROW_W-1:0] row;
        logic             final_row;
    } t_tag;

endpackage

`default_nettype wire

@@ hw/rtl/state_space_derivative.sv @@
// ----------------------------------------------------------------------------
// State-space derivative: dx/dt = A*x + B*u in signed Q16.16
// Loads A, B and u, takes x element by element and emits one derivative beat
// per active state row once the final state element arrives.
// ----------------------------------------------------------------------------
// Load, control-input and non-final state beats only write the stores.
// A final state beat starts one multiply-accumulate per cycle over sd + id
// terms per row, row by row. busy stays high until the final row's result
// beat, and no beat is accepted meanwhile; the single read port of the
// matrix memory and the one multiplier set the pace. Results cannot be stalled.
// Reset (synchronous, active low) clears the sequencer and the pipe valids and
// sets state_dim to 8 and input_dim to 4; the memories keep their contents.
`timescale 1ns / 1ps
`default_nettype none

module state_space_derivative (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Command channel
    input  wire logic                              start,
    output      logic                              busy,
    input  wire ssd_pkg::t_item                    i_item,
    // Configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [ssd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [ssd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Result channel
    output      logic                              o_res_strobe,
    output      ssd_pkg::t_result                  o_result
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ssd_pkg::SD_W-1:0] r_state_dim;
    logic [ssd_pkg::ID_W-1:0] r_input_dim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state_dim <= ssd_pkg::SD_W'(8);
            r_input_dim <= ssd_pkg::ID_W'(4);
        end else if (i_cfg_we) begin
            unique case (ssd_pkg::t_cfg_reg'(i_cfg_index))
                ssd_pkg::CFG_STATE_DIM: r_state_dim <= i_cfg_data[ssd_pkg::SD_W-1:0];
                ssd_pkg::CFG_INPUT_DIM: r_input_dim <= i_cfg_data[ssd_pkg::ID_W-1:0];
                default:                ;
            endcase
        end
    end

    // The dimensions are clamped into their legal ranges when a computation
    // starts; a zero dimension behaves as one.
    logic [ssd_pkg::ROW_W-1:0] w_sd_m1;
    logic [ssd_pkg::CNT_W-1:0] w_id_m1;

    always_comb begin
        if (r_state_dim == '0) begin
            w_sd_m1 = '0;
        end else if (int'(r_state_dim) > ssd_pkg::ROW_CAP) begin
            w_sd_m1 = ssd_pkg::ROW_W'(ssd_pkg::ROW_CAP - 1);
        end else begin
            w_sd_m1 = ssd_pkg::ROW_W'(r_state_dim - 1'b1);
        end
        if (r_input_dim == '0) begin
            w_id_m1 = '0;
        end else if (int'(r_input_dim) > ssd_pkg::MAX_INPUTS) begin
            w_id_m1 = ssd_pkg::CNT_W'(ssd_pkg::MAX_INPUTS - 1);
        end else begin
            w_id_m1 = ssd_pkg::CNT_W'(r_input_dim - 1'b1);
        end
    end

    // ------------------------------------------------------------------
    // Command acceptance and store writes
    // ------------------------------------------------------------------
    // A and B share one matrix memory (A first, B from B_BASE); x and u share
    // one vector memory (x first, u from U_BASE). Entries whose indices fall
    // outside a store are simply not written.
    logic                         w_accept;
    logic                         w_go;
    logic                         w_mat_we;
    logic                         w_vec_we;
    logic [ssd_pkg::MAT_AW-1:0]   w_mat_waddr;
    logic [ssd_pkg::VEC_AW-1:0]   w_vec_waddr;

    assign w_accept = start && !busy;
    assign w_go     = w_accept && (i_item.mode == ssd_pkg::MODE_STATE) && i_item.last;

    always_comb begin
        w_mat_we    = 1'b0;
        w_vec_we    = 1'b0;
        w_mat_waddr = '0;
        w_vec_waddr = '0;
        unique case (i_item.mode)
            ssd_pkg::MODE_LOAD_A: begin
                w_mat_we    = w_accept && (int'(i_item.row) < ssd_pkg::MAX_STATES)
                              && (int'(i_item.col) < ssd_pkg::MAX_STATES);
                w_mat_waddr = ssd_pkg::MAT_AW'(i_item.row) * ssd_pkg::MAT_AW'(ssd_pkg::MAX_STATES)
                              + ssd_pkg::MAT_AW'(i_item.col);
            end
            ssd_pkg::MODE_LOAD_B: begin
                w_mat_we    = w_accept && (int'(i_item.row) < ssd_pkg::MAX_STATES)
                              && (int'(i_item.col) < ssd_pkg::MAX_INPUTS);
                w_mat_waddr = ssd_pkg::MAT_AW'(ssd_pkg::B_BASE)
                              + ssd_pkg::MAT_AW'(i_item.row) * ssd_pkg::MAT_AW'(ssd_pkg::MAX_INPUTS)
                              + ssd_pkg::MAT_AW'(i_item.col);
            end
            ssd_pkg::MODE_SET_U: begin
                w_vec_we    = w_accept && (int'(i_item.row) < ssd_pkg::MAX_INPUTS);
                w_vec_waddr = ssd_pkg::VEC_AW'(ssd_pkg::U_BASE) + ssd_pkg::VEC_AW'(i_item.row);
            end
            ssd_pkg::MODE_STATE: begin
                w_vec_we    = w_accept && (int'(i_item.row) < ssd_pkg::MAX_STATES);
                w_vec_waddr = ssd_pkg::VEC_AW'(i_item.row);
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: walks row j, first over the A terms then over the B terms.
    // ------------------------------------------------------------------
    ssd_pkg::t_seq_state        r_state;
    ssd_pkg::t_seq_state        n_state;
    logic [ssd_pkg::ROW_W-1:0]  r_row;
    logic [ssd_pkg::CNT_W-1:0]  r_col;
    logic                       r_phase_b;
    logic [ssd_pkg::ROW_W-1:0]  r_sd_m1;
    logic [ssd_pkg::CNT_W-1:0]  r_id_m1;
    logic                       w_issue;
    logic                       w_a_end;
    logic                       w_term_last;
    logic                       w_row_last;
    ssd_pkg::t_tag              w_issue_tag;
    logic [ssd_pkg::MAT_AW-1:0] w_mat_raddr;
    logic [ssd_pkg::VEC_AW-1:0] w_vec_raddr;

    // Pipeline registers declared here, as the drain condition reads them.
    logic                       r_s3_done;
    ssd_pkg::t_tag              r_s3_tag;

    assign w_a_end     = !r_phase_b && (r_col == ssd_pkg::CNT_W'(r_sd_m1));
    assign w_term_last = r_phase_b && (r_col == r_id_m1);
    assign w_row_last  = (r_row == r_sd_m1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ssd_pkg::SEQ_IDLE:  if (w_go) n_state = ssd_pkg::SEQ_RUN;
            ssd_pkg::SEQ_RUN:   if (w_term_last && w_row_last) n_state = ssd_pkg::SEQ_DRAIN;
            ssd_pkg::SEQ_DRAIN: if (r_s3_done && r_s3_tag.final_row) n_state = ssd_pkg::SEQ_IDLE;
            default:            n_state = ssd_pkg::SEQ_IDLE;
        endcase
    end

    always_comb begin
        unique case (r_state)
            ssd_pkg::SEQ_IDLE: begin
                busy    = 1'b0;
                w_issue = 1'b0;
            end
            ssd_pkg::SEQ_RUN: begin
                busy    = 1'b1;
                w_issue = 1'b1;
            end
            ssd_pkg::SEQ_DRAIN: begin
                busy    = 1'b1;
                w_issue = 1'b0;
            end
            default: begin
                busy    = 1'b1;
                w_issue = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ssd_pkg::SEQ_IDLE;
            r_row     <= '0;
            r_col     <= '0;
            r_phase_b <= 1'b0;
            r_sd_m1   <= '0;
            r_id_m1   <= '0;
        end else begin
            r_state <= n_state;
            if (w_go) begin
                r_row     <= '0;
                r_col     <= '0;
                r_phase_b <= 1'b0;
                r_sd_m1   <= w_sd_m1;
                r_id_m1   <= w_id_m1;
            end else if (w_issue) begin
                if (w_a_end) begin
                    r_phase_b <= 1'b1;
                    r_col     <= '0;
                end else if (w_term_last) begin
                    r_phase_b <= 1'b0;
                    r_col     <= '0;
                    r_row     <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    always_comb begin
        w_issue_tag.first_term = !r_phase_b && (r_col == '0);
        w_issue_tag.last_term  = w_term_last;
        w_issue_tag.row        = r_row;
        w_issue_tag.final_row  = w_row_last;
        if (r_phase_b) begin
            w_mat_raddr = ssd_pkg::MAT_AW'(ssd_pkg::B_BASE)
                          + ssd_pkg::MAT_AW'(r_row) * ssd_pkg::MAT_AW'(ssd_pkg::MAX_INPUTS)
                          + ssd_pkg::MAT_AW'(r_col);
            w_vec_raddr = ssd_pkg::VEC_AW'(ssd_pkg::U_BASE) + ssd_pkg::VEC_AW'(r_col);
        end else begin
            w_mat_raddr = ssd_pkg::MAT_AW'(r_row) * ssd_pkg::MAT_AW'(ssd_pkg::MAX_STATES)
                          + ssd_pkg::MAT_AW'(r_col);
            w_vec_raddr = ssd_pkg::VEC_AW'(r_col);
        end
    end

    // ------------------------------------------------------------------
    // Memories: one write and one registered read per cycle each.
    // Writes only happen while the sequencer is idle, and the x element of
    // the final state beat is written before the first read, so no
    // forwarding path is needed.
    // ------------------------------------------------------------------
    logic [ssd_pkg::VALUE_W-1:0]        r_mat_mem [ssd_pkg::MAT_DEPTH];
    logic [ssd_pkg::VALUE_W-1:0]        r_vec_mem [ssd_pkg::VEC_DEPTH];
    logic signed [ssd_pkg::VALUE_W-1:0] r_mat_q;
    logic signed [ssd_pkg::VALUE_W-1:0] r_vec_q;

    always_ff @(posedge i_clk) begin
        if (w_mat_we) begin
            r_mat_mem[w_mat_waddr] <= i_item.value;
        end
        r_mat_q <= r_mat_mem[w_mat_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_vec_we) begin
            r_vec_mem[w_vec_waddr] <= i_item.value;
        end
        r_vec_q <= r_vec_mem[w_vec_raddr];
    end

    // ------------------------------------------------------------------
    // Multiply-accumulate pipe: read, multiply, accumulate, round.
    // ------------------------------------------------------------------
    logic                              r_s1_vld;
    ssd_pkg::t_tag                     r_s1_tag;
    logic                              r_s2_vld;
    ssd_pkg::t_tag                     r_s2_tag;
    logic signed [ssd_pkg::PROD_W-1:0] r_prod;
    logic signed [ssd_pkg::ACC_W-1:0]  r_acc;
    logic signed [ssd_pkg::ACC_W-1:0]  w_prod_ext;

    assign w_prod_ext = {{(ssd_pkg::ACC_W - ssd_pkg::PROD_W){r_prod[ssd_pkg::PROD_W-1]}}, r_prod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_done <= 1'b0;
        end else begin
            r_s1_vld  <= w_issue;
            r_s2_vld  <= r_s1_vld;
            r_s3_done <= r_s2_vld && r_s2_tag.last_term;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_tag <= w_issue_tag;
        r_s2_tag <= r_s1_tag;
        r_prod   <= r_mat_q * r_vec_q;
        r_s3_tag <= r_s2_tag;
        if (r_s2_vld) begin
            // The first term of a row restarts the sum.
            r_acc <= (r_s2_tag.first_term ? '0 : r_acc) + w_prod_ext;
        end
    end

    // Round half towards plus infinity, then clip to Q16.16.
    logic signed [ssd_pkg::ACC_W-1:0]       w_rnd_sum;
    logic signed [ssd_pkg::RND_W-1:0]       w_rounded;
    logic [ssd_pkg::RND_W-ssd_pkg::VALUE_W:0] w_top;
    logic                                   w_pos_ovf;
    logic                                   w_neg_ovf;

    assign w_rnd_sum = r_acc + ssd_pkg::ACC_W'(ssd_pkg::ROUND_HALF);
    assign w_rounded = w_rnd_sum[ssd_pkg::ACC_W-1:ssd_pkg::FRAC_W];
    assign w_top     = w_rounded[ssd_pkg::RND_W-1:ssd_pkg::VALUE_W-1];
    assign w_pos_ovf = !w_rounded[ssd_pkg::RND_W-1] && (|w_top);
    assign w_neg_ovf = w_rounded[ssd_pkg::RND_W-1] && !(&w_top);

    logic             r_out_vld;
    ssd_pkg::t_result r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_s3_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s3_done) begin
            r_out.index     <= r_s3_tag.row;
            r_out.saturated <= w_pos_ovf || w_neg_ovf;
            r_out.final_res <= r_s3_tag.final_row;
            priority if (w_pos_ovf) begin
                r_out.derivative <= ssd_pkg::SAT_MAX;
            end else if (w_neg_ovf) begin
                r_out.derivative <= ssd_pkg::SAT_MIN;
            end else begin
                r_out.derivative <= w_rounded[ssd_pkg::VALUE_W-1:0];
            end
        end
    end

    assign o_res_strobe = r_out_vld;
    assign o_result     = r_out;

endmodule

`default_nettype wire

@@ hw/rtl/ssd_checker.sv @@
// ----------------------------------------------------------------------------
// State-space derivative checker
// Port-level properties of the derivative block, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "state_space_derivative_defines.svh"

module ssd_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire ssd_pkg::t_item   i_item,
    input wire logic             o_res_strobe,
    input wire ssd_pkg::t_result o_result
);

    // A final state beat always starts a computation.
    `SSD_ASSERT_NEXT(a_go_sets_busy, start && !busy && (i_item.mode == ssd_pkg::MODE_STATE) && i_item.last, busy, "final state beat did not start a computation")

    // Only the last row of a vector may appear once the block is idle again.
    `SSD_ASSERT_NOW(a_inner_row_busy, o_res_strobe && !o_result.final_res, busy, "non-final result beat while idle")

    // The block only falls idle together with the last row of the vector.
    `SSD_ASSERT_NOW(a_idle_on_final, $fell(busy) && $past(i_rst_n), o_res_strobe && o_result.final_res, "busy fell without a final result beat")

    // Nothing follows the last row directly.
    `SSD_ASSERT_NEXT(a_gap_after_final, o_res_strobe && o_result.final_res, !o_res_strobe, "result beat directly after the final one")

    // Reset leaves the block idle and quiet.
    `SSD_ASSERT_RESET(a_reset_quiet, !busy && !o_res_strobe, "block not idle after reset")

endmodule

bind state_space_derivative ssd_checker u_ssd_checker (.*);

`default_nettype wire
